@@ rtl/core/hll_dense_register_update_assert.svh @@
// ----------------------------------------------------------------------------
// HLL dense register update - assertion macros
// Clocked concurrent assertions with an asynchronous active-low disable.
// ----------------------------------------------------------------------------
`ifndef HLL_DENSE_REGISTER_UPDATE_ASSERT_SVH
`define HLL_DENSE_REGISTER_UPDATE_ASSERT_SVH

// same-cycle implication
`define HDRU_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HDRU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/hdru_pkg.sv @@
// ----------------------------------------------------------------------------
// HLL dense register update - package
// Sizes, hash constants and the status structs shared by the core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hdru_pkg;

	localparam int MAX_PRECISION = 14;
	localparam int MIN_PRECISION = 4;
	localparam int PREC_RESET    = (MAX_PRECISION < 14) ? MAX_PRECISION : 14;
	localparam int PREC_W        = 4;
	localparam int ID_W          = 32;
	localparam int HASH_BITS     = 64;
	localparam int HALF_W        = HASH_BITS / 2;
	localparam int FRAC_BITS     = 49;
	localparam int RANK_W        = 6;
	localparam int LZ_W          = $clog2(HASH_BITS);
	localparam int LZ_STEPS      = $clog2(HASH_BITS);
	localparam int BUCKET_W      = MAX_PRECISION;
	localparam int ZC_W          = MAX_PRECISION + 1;
	localparam int STORE_DEPTH   = 1 << MAX_PRECISION;

	localparam logic [HASH_BITS-1:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [HASH_BITS-1:0] MIX_M1    = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [HASH_BITS-1:0] MIX_M2    = 64'h94D0_49BB_1331_11EB;

	typedef struct packed {
		logic                 done;
		logic [HASH_BITS-1:0] value;
	} hash_res_t;

	typedef struct packed {
		logic            done;
		logic            zero;
		logic [LZ_W-1:0] count;
	} lzc_res_t;

endpackage

`default_nettype wire

@@ rtl/core/hdru_hash.sv @@
// ----------------------------------------------------------------------------
// HLL dense register update - hash unit
// Mixer over one shared 32x32 multiplier; each 64-bit product takes four steps.
// ----------------------------------------------------------------------------
`default_nettype none

module hdru_hash (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [hdru_pkg::ID_W-1:0] item_id,
	output hdru_pkg::hash_res_t      res
);
	import hdru_pkg::*;

	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_M1   = 2'd1;
	localparam logic [1:0] H_M2   = 2'd2;

	localparam logic [1:0] STEP_LL  = 2'd0;
	localparam logic [1:0] STEP_HL  = 2'd1;
	localparam logic [1:0] STEP_LH  = 2'd2;
	localparam logic [1:0] STEP_FIN = 2'd3;

	localparam int SHIFT_0 = 30;
	localparam int SHIFT_1 = 27;
	localparam int SHIFT_2 = 31;

	logic [1:0]           state_q;
	logic [1:0]           step_q;
	logic                 done_q;
	logic [HASH_BITS-1:0] a_q;
	logic [HASH_BITS-1:0] acc_q;
	logic [HASH_BITS-1:0] prod_q;
	logic [HASH_BITS-1:0] h_q;

	logic [HASH_BITS-1:0] mult_k;
	logic [HALF_W-1:0]    mul_a;
	logic [HALF_W-1:0]    mul_b;
	logic [HASH_BITS-1:0] seed;
	logic [HASH_BITS-1:0] z_fin;

	assign mult_k = (state_q == H_M1) ? MIX_M1 : MIX_M2;
	assign seed   = {{(HASH_BITS-ID_W){1'b0}}, item_id} + MIX_GAMMA;
	// cross products only reach the upper half of the low 64 bits
	assign z_fin  = {acc_q[HASH_BITS-1:HALF_W] + prod_q[HALF_W-1:0], acc_q[HALF_W-1:0]};

	always_comb begin
		case (step_q)
			STEP_HL: begin
				mul_a = a_q[HASH_BITS-1:HALF_W];
				mul_b = mult_k[HALF_W-1:0];
			end
			STEP_LH: begin
				mul_a = a_q[HALF_W-1:0];
				mul_b = mult_k[HASH_BITS-1:HALF_W];
			end
			default: begin
				mul_a = a_q[HALF_W-1:0];
				mul_b = mult_k[HALF_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			step_q  <= STEP_LL;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				H_IDLE: begin
					if (start) begin
						state_q <= H_M1;
						step_q  <= STEP_LL;
					end
				end
				H_M1, H_M2: begin
					step_q <= step_q + 2'd1;
					if (step_q == STEP_FIN) begin
						state_q <= (state_q == H_M1) ? H_M2 : H_IDLE;
						done_q  <= (state_q == H_M2);
					end
				end
				default: begin
					state_q <= H_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
		if (state_q == H_IDLE) begin
			if (start) begin
				a_q <= seed ^ (seed >> SHIFT_0);
			end
		end else begin
			case (step_q)
				STEP_HL: begin
					acc_q <= prod_q;
				end
				STEP_LH: begin
					acc_q[HASH_BITS-1:HALF_W] <= acc_q[HASH_BITS-1:HALF_W]
						+ prod_q[HALF_W-1:0];
				end
				STEP_FIN: begin
					if (state_q == H_M1) begin
						a_q <= z_fin ^ (z_fin >> SHIFT_1);
					end else begin
						h_q <= z_fin ^ (z_fin >> SHIFT_2);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.done  = done_q;
	assign res.value = h_q;

endmodule

`default_nettype wire

@@ rtl/core/hdru_lzc.sv @@
// ----------------------------------------------------------------------------
// HLL dense register update - leading-zero counter
// Binary search over the 64-bit word, one halving step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hdru_lzc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hdru_pkg::HASH_BITS-1:0] value,
	output hdru_pkg::lzc_res_t            res
);
	import hdru_pkg::*;

	localparam int STEP_W = $clog2(LZ_STEPS);

	logic                 run_q;
	logic                 done_q;
	logic [STEP_W-1:0]    step_q;
	logic [HASH_BITS-1:0] w_q;
	logic [LZ_W-1:0]      n_q;

	logic [LZ_W-1:0]      half;
	logic [HASH_BITS-1:0] mask;
	logic                 top_zero;

	always_comb begin
		half     = LZ_W'(HALF_W >> step_q);
		mask     = ~({HASH_BITS{1'b1}} >> half);
		top_zero = ((w_q & mask) == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(LZ_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			w_q <= value;
			n_q <= '0;
		end else if (run_q && top_zero) begin
			// shift the empty upper part out
			w_q <= w_q << half;
			n_q <= n_q + half;
		end
	end

	assign res.done  = done_q;
	assign res.zero  = ~w_q[HASH_BITS-1];
	assign res.count = n_q;

endmodule

`default_nettype wire

@@ rtl/core/hll_dense_register_update.sv @@
// ----------------------------------------------------------------------------
// HLL dense register update - top level
// Hashes each item, raises its bucket's rank and keeps the zero-bucket count
// and the fixed-point sum of two to the minus rank.
//
//   channel   signals                                    handshake
//   item      start, busy, item_id                       start & !busy
//   result    done, bucket, rank, raised,                done strobe, 1 cycle
//             empty_buckets, inverse_sum
//   config    cfg_we, cfg_wdata (precision)              cfg_we, no wait
//
// An item passes through the shared 32x32 hash multiplier, then the
// leading-zero search, then the rank read-modify-write and the sum update;
// a new item is taken in its done cycle. Reset and every precision write
// start a clearing pass over all 2^precision rank entries (16 to 16384);
// busy is high meanwhile. The result cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hll_dense_register_update_assert.svh"

module hll_dense_register_update (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [hdru_pkg::ID_W-1:0]         item_id,
	input  logic                              cfg_we,
	input  logic [hdru_pkg::PREC_W-1:0]       cfg_wdata,
	output logic                              done,
	output logic [hdru_pkg::BUCKET_W-1:0]     bucket,
	output logic [hdru_pkg::RANK_W-1:0]       rank,
	output logic                              raised,
	output logic [hdru_pkg::ZC_W-1:0]         empty_buckets,
	output logic [hdru_pkg::HASH_BITS-1:0]    inverse_sum
);
	import hdru_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_LZS   = 3'd3;
	localparam logic [2:0] S_LZC   = 3'd4;
	localparam logic [2:0] S_ADD   = 3'd5;
	localparam logic [2:0] S_SUB   = 3'd6;

	function automatic logic [PREC_W-1:0] clamp_prec(input logic [PREC_W-1:0] v);
		logic [PREC_W-1:0] p;
		if (int'(v) < MIN_PRECISION) begin
			p = PREC_W'(MIN_PRECISION);
		end else if (int'(v) > MAX_PRECISION) begin
			p = PREC_W'(MAX_PRECISION);
		end else begin
			p = v;
		end
		return p;
	endfunction

	// 2^-r with FRAC_BITS fraction bits; terms below resolution drop to zero
	function automatic logic [HASH_BITS-1:0] inv_term(input logic [RANK_W-1:0] r);
		logic [HASH_BITS-1:0] t;
		if (int'(r) > FRAC_BITS) begin
			t = '0;
		end else begin
			t = HASH_BITS'(1) << (FRAC_BITS - int'(r));
		end
		return t;
	endfunction

	logic [2:0]           state_q;
	logic [PREC_W-1:0]    prec_q;
	logic [BUCKET_W-1:0]  clr_q;
	logic [ZC_W-1:0]      zc_q;
	logic [HASH_BITS-1:0] sum_q;
	logic                 done_q;

	logic [BUCKET_W-1:0]  idx_q;
	logic [HASH_BITS-1:0] w_q;
	logic [RANK_W-1:0]    rank_q;
	logic [RANK_W-1:0]    rd_q;
	logic [RANK_W-1:0]    old_q;
	logic                 up_q;

	logic [RANK_W-1:0]    rank_mem [STORE_DEPTH];

	hash_res_t            hash_res;
	lzc_res_t             lzc_res;
	logic                 accept;
	logic [PREC_W-1:0]    cfg_prec;
	logic [BUCKET_W-1:0]  clr_last;
	logic                 up;
	logic                 mem_we;
	logic [BUCKET_W-1:0]  mem_wa;
	logic [RANK_W-1:0]    mem_wd;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign cfg_prec = clamp_prec(cfg_wdata);
	assign clr_last = {BUCKET_W{1'b1}} >> (BUCKET_W - int'(prec_q));
	assign up       = (rank_q > rd_q);

	hdru_hash u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.item_id (item_id),
		.res     (hash_res)
	);

	hdru_lzc u_lzc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LZS),
		.value  (w_q),
		.res    (lzc_res)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = rank_q;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == S_ADD) begin
			mem_we = up;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rank_mem[mem_wa] <= mem_wd;
		end
		rd_q <= rank_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			prec_q  <= PREC_W'(PREC_RESET);
			clr_q   <= '0;
			zc_q    <= ZC_W'(1) << PREC_RESET;
			sum_q   <= HASH_BITS'(1) << (FRAC_BITS + PREC_RESET);
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				// fresh sketch for the new bucket count
				prec_q  <= cfg_prec;
				state_q <= S_CLEAR;
				clr_q   <= '0;
				zc_q    <= ZC_W'(1) << cfg_prec;
				sum_q   <= HASH_BITS'(1) << (FRAC_BITS + int'(cfg_prec));
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + BUCKET_W'(1);
						if (clr_q == clr_last) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (start) begin
							state_q <= S_HASH;
						end
					end
					S_HASH: begin
						if (hash_res.done) begin
							state_q <= S_LZS;
						end
					end
					S_LZS: begin
						state_q <= S_LZC;
					end
					S_LZC: begin
						if (lzc_res.done) begin
							state_q <= S_ADD;
						end
					end
					S_ADD: begin
						if (up) begin
							sum_q <= sum_q + inv_term(rank_q);
							if ((rd_q == '0) && (zc_q != '0)) begin
								zc_q <= zc_q - ZC_W'(1);
							end
						end
						state_q <= S_SUB;
					end
					S_SUB: begin
						if (up_q) begin
							sum_q <= sum_q - inv_term(old_q);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_HASH) && hash_res.done) begin
			idx_q <= hash_res.value[HASH_BITS-1 -: BUCKET_W] >> (BUCKET_W - int'(prec_q));
			w_q   <= hash_res.value << prec_q;
		end
		if ((state_q == S_LZC) && lzc_res.done) begin
			if (lzc_res.zero) begin
				rank_q <= RANK_W'(HASH_BITS + 1 - int'(prec_q));
			end else begin
				rank_q <= RANK_W'(int'(lzc_res.count) + 1);
			end
		end
		if (state_q == S_ADD) begin
			up_q  <= up;
			old_q <= rd_q;
		end
	end

	assign done          = done_q;
	assign bucket        = idx_q;
	assign rank          = rank_q;
	assign raised        = up_q;
	assign empty_buckets = zc_q;
	assign inverse_sum   = sum_q;

	`HDRU_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`HDRU_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe held")
	`HDRU_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "request not held")
	`HDRU_ASSERT_NOW(a_rank_nz, clk, arst_n, done, rank != '0, "zero rank reported")
	`HDRU_ASSERT_NOW(a_zc_range, clk, arst_n, 1'b1, zc_q <= (ZC_W'(1) << prec_q), "zero count overrun")

endmodule

`default_nettype wire
